// ----- sv/uu64le_pkg.sv -----
// ----------------------------------------------------------------------------
// uu64le_pkg
// Shared types, constants and character functions of the line encoder.
// ----------------------------------------------------------------------------
package uu64le_pkg;

  localparam int unsigned MAX_LINE_BYTES_DEF = 45;
  localparam int unsigned CNT_W              = 6;
  localparam int unsigned BYTE_W             = 8;

  localparam logic [BYTE_W-1:0] CH_NL      = 8'd10;
  localparam logic [BYTE_W-1:0] CH_UU_PAD  = 8'h60;
  localparam logic [BYTE_W-1:0] CH_B64_PAD = 8'h3D;
  localparam logic [BYTE_W-1:0] UU_OFS     = 8'd32;

  localparam logic [0:0] REG_MODE = 1'b0;
  localparam logic [0:0] REG_LINE = 1'b1;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LEN,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_NL
  } state_t;

  typedef struct packed {
    logic              we;
    logic [CNT_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [CNT_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic             uu;
    logic [CNT_W-1:0] eff;
  } cfg_t;

  function automatic logic [CNT_W-1:0] floor3(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = '0;
    for (int k = 0; k < 22; k++) begin
      if (CNT_W'(3 * k) <= v) r = CNT_W'(3 * k);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] v,
                                               input logic [CNT_W-1:0] mx);
    logic [CNT_W-1:0] s;
    s = (v <= CNT_W'(2) || v > mx) ? mx : v;
    return floor3(s);
  endfunction

  function automatic logic [BYTE_W-1:0] enc_char(input logic [5:0] v,
                                                 input logic       uu);
    logic [BYTE_W-1:0] c;
    if (uu) begin
      c = (v == 6'd0) ? CH_UU_PAD : ({2'b00, v} + UU_OFS);
    end else if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else begin
      c = (v == 6'd62) ? 8'h2B : 8'h2F;
    end
    return c;
  endfunction

endpackage

// ----- sv/uu64le_store.sv -----
// ----------------------------------------------------------------------------
// uu64le_store
// Line buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uu64le_store #(
  parameter int unsigned DEPTH = uu64le_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  uu64le_pkg::mem_req_t           req,
  output logic [uu64le_pkg::BYTE_W-1:0]  rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [uu64le_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [uu64le_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we && req.waddr < uu64le_pkg::CNT_W'(DEPTH)) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  // address past the end leaves the last data in place; caller masks it
  always_ff @(posedge clk) begin
    if (req.re && req.raddr < uu64le_pkg::CNT_W'(DEPTH)) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/uu64le_seq.sv -----
// ----------------------------------------------------------------------------
// uu64le_seq
// Collects bytes into the line buffer, then walks it one group at a time
// and drives the character stream through an output register.
// ----------------------------------------------------------------------------
module uu64le_seq #(
  parameter int unsigned MAX_LINE_BYTES = uu64le_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  uu64le_pkg::cfg_t               cfg,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [uu64le_pkg::BYTE_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [uu64le_pkg::BYTE_W-1:0]  out_tdata,
  output logic                           out_tlast,
  output uu64le_pkg::mem_req_t           mem_req,
  input  logic [uu64le_pkg::BYTE_W-1:0]  mem_rdata
);

  localparam int unsigned CW = uu64le_pkg::CNT_W;
  localparam int unsigned BW = uu64le_pkg::BYTE_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_LINE_BYTES);

  uu64le_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [BW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic          step_ok;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] i1, i2, i3;
  logic [BW-1:0] b_eff, c_eff, pad;

  assign step_ok = !out_valid_r || out_tready;
  assign i1      = i_r + CW'(1);
  assign i2      = i_r + CW'(2);
  assign i3      = i_r + CW'(3);
  assign b_eff   = (i1 < n_r) ? mem_rdata : '0;
  assign c_eff   = (i2 < n_r) ? mem_rdata : '0;
  assign pad     = cfg.uu ? uu64le_pkg::CH_UU_PAD : uu64le_pkg::CH_B64_PAD;
  assign cnt_inc = (cnt_r < MAXC) ? cnt_r + CW'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uu64le_pkg::ST_COLLECT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    mem_req       = '0;

    unique case (state_r)
      uu64le_pkg::ST_COLLECT: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mem_req.we    = (cnt_r < MAXC);
          mem_req.waddr = cnt_r;
          mem_req.wdata = in_tdata;
          if (cnt_inc >= cfg.eff || in_tlast) begin
            n_nxt     = cnt_inc;
            cnt_nxt   = '0;
            i_nxt     = '0;
            state_nxt = uu64le_pkg::ST_LEN;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      uu64le_pkg::ST_LEN: begin
        if (!cfg.uu) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = '0;
          state_nxt     = uu64le_pkg::ST_G0;
        end else if (step_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = BW'(n_r) + uu64le_pkg::UU_OFS;
          out_last_nxt  = 1'b0;
          mem_req.re    = 1'b1;
          mem_req.raddr = '0;
          state_nxt     = uu64le_pkg::ST_G0;
        end
      end
      uu64le_pkg::ST_G0: begin
        if (step_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = uu64le_pkg::enc_char(mem_rdata[7:2], cfg.uu);
          out_last_nxt  = 1'b0;
          a_nxt         = mem_rdata;
          mem_req.re    = 1'b1;
          mem_req.raddr = i1;
          state_nxt     = uu64le_pkg::ST_G1;
        end
      end
      uu64le_pkg::ST_G1: begin
        if (step_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = uu64le_pkg::enc_char({a_r[1:0], b_eff[7:4]}, cfg.uu);
          out_last_nxt  = 1'b0;
          b_nxt         = b_eff;
          mem_req.re    = 1'b1;
          mem_req.raddr = i2;
          state_nxt     = uu64le_pkg::ST_G2;
        end
      end
      uu64le_pkg::ST_G2: begin
        if (step_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (i1 >= n_r) ? pad :
                          uu64le_pkg::enc_char({b_r[3:0], c_eff[7:6]}, cfg.uu);
          out_last_nxt  = 1'b0;
          c_nxt         = c_eff;
          mem_req.re    = 1'b1;
          mem_req.raddr = i3;
          state_nxt     = uu64le_pkg::ST_G3;
        end
      end
      uu64le_pkg::ST_G3: begin
        if (step_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (i2 >= n_r) ? pad : uu64le_pkg::enc_char(c_r[5:0], cfg.uu);
          out_last_nxt  = 1'b0;
          i_nxt         = i3;
          state_nxt     = (i3 < n_r) ? uu64le_pkg::ST_G0 : uu64le_pkg::ST_NL;
        end
      end
      uu64le_pkg::ST_NL: begin
        if (step_ok) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = uu64le_pkg::CH_NL;
          out_last_nxt  = 1'b1;
          state_nxt     = uu64le_pkg::ST_COLLECT;
        end
      end
      default: state_nxt = uu64le_pkg::ST_COLLECT;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/uu_base64_line_encoder_core.sv -----
// ----------------------------------------------------------------------------
// uu_base64_line_encoder_core
// Base64 / uuencode line encoder: bytes in, one encoded line out per flush.
// ----------------------------------------------------------------------------
// Collecting: one byte per cycle, written straight into the line buffer.
// Flush of n bytes: ST_LEN starts the buffer read (length char in uu mode),
//   ST_G0..ST_G3 give the four chars of each 3-byte group, ST_NL the newline;
//   every char step waits for the output register to be free.
// No byte is accepted while a line is being flushed.
// rst_n (synchronous): empty line, base64 mode, 45-byte lines; buffer not cleared.
module uu_base64_line_encoder_core #(
  parameter int unsigned MAX_LINE_BYTES = uu64le_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_addr,
  input  logic [uu64le_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [uu64le_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // end_of_data
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [uu64le_pkg::BYTE_W-1:0]  out_tdata,  // [7:0] out_char
  output logic                           out_tlast   // last_of_run
);

  localparam int unsigned CW = uu64le_pkg::CNT_W;
  localparam logic [CW-1:0] MAXC    = CW'(MAX_LINE_BYTES);
  localparam logic [CW-1:0] EFF_RST = uu64le_pkg::floor3(MAXC);

  logic          mode_r, mode_nxt;
  logic [CW-1:0] eff_r, eff_nxt;

  uu64le_pkg::cfg_t                cfg;
  uu64le_pkg::mem_req_t            mem_req;
  logic [uu64le_pkg::BYTE_W-1:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      eff_r  <= EFF_RST;
    end else begin
      mode_r <= mode_nxt;
      eff_r  <= eff_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    eff_nxt  = eff_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        uu64le_pkg::REG_MODE: mode_nxt = cfg_wdata[0];
        uu64le_pkg::REG_LINE: eff_nxt  = uu64le_pkg::eff_len(cfg_wdata, MAXC);
        default: ;
      endcase
    end
  end

  assign cfg.uu  = mode_r;
  assign cfg.eff = eff_r;

  uu64le_seq #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  uu64le_store #(
    .DEPTH (MAX_LINE_BYTES)
  ) u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  a_wr_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (in_tvalid && in_tready))
    else $error("line buffer written without an input transfer");

  a_flush_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("end of data did not start a flush");

  a_nl_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == uu64le_pkg::CH_NL))
    else $error("line end without newline");

  a_eff_range: assert property (@(posedge clk) disable iff (!rst_n)
    (eff_r >= CW'(3)) && (eff_r <= MAXC))
    else $error("effective line length out of range");

endmodule

// ----- tb/tb_uu_base64_line_encoder_core.sv -----
// ----------------------------------------------------------------------------
// tb_uu_base64_line_encoder_core
// Self-checking bench for the base64 / uuencode line encoder. Bytes are
// streamed in with random input gaps and random output back-pressure; every accepted
// byte is run through a local line encoder that queues the characters the
// block must emit, and each output transfer is checked against the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uu_base64_line_encoder_core;

  localparam int unsigned BYTE_W             = uu64le_pkg::BYTE_W;
  localparam int unsigned CNT_W              = uu64le_pkg::CNT_W;
  localparam int unsigned MAX_LINE_BYTES_DEF = uu64le_pkg::MAX_LINE_BYTES_DEF;

  localparam logic [BYTE_W-1:0] CH_NL      = uu64le_pkg::CH_NL;
  localparam logic [BYTE_W-1:0] CH_UU_PAD  = uu64le_pkg::CH_UU_PAD;
  localparam logic [BYTE_W-1:0] CH_B64_PAD = uu64le_pkg::CH_B64_PAD;
  localparam logic [BYTE_W-1:0] UU_OFS     = uu64le_pkg::UU_OFS;

  localparam logic [0:0] REG_MODE = uu64le_pkg::REG_MODE;
  localparam logic [0:0] REG_LINE = uu64le_pkg::REG_LINE;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              nl;
  } enc_char_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [0:0]        cfg_addr   = REG_MODE;
  logic [CNT_W-1:0]  cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BYTE_W-1:0] out_tdata;
  logic              out_tlast;

  // local copy of the encoder state
  logic [BYTE_W-1:0] line_buf [MAX_LINE_BYTES_DEF];
  int                line_cnt;
  logic              uu_mode;
  logic [CNT_W-1:0]  line_cfg;

  enc_char_t         pending_chars [$];
  enc_char_t         head_char;
  int                errors;
  int                bytes_sent;
  int                send_idle_pct;
  int                recv_idle_pct;

  uu_base64_line_encoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] data_byte
    .in_tlast  (in_tlast),   // end_of_data
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] out_char
    .out_tlast (out_tlast)   // last_of_run
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_uu_base64_line_encoder_core: done, errors");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] sextet_char(input logic [5:0] v, input logic uu);
    if (uu) return (v == 6'd0) ? CH_UU_PAD : ({2'b00, v} + UU_OFS);
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    if (v < 6'd52) return 8'h61 + {2'b00, v} - 8'd26;
    if (v < 6'd62) return 8'h30 + {2'b00, v} - 8'd52;
    return (v == 6'd62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic int line_limit();
    int n;
    n = int'(line_cfg);
    if (n <= 2 || n > int'(MAX_LINE_BYTES_DEF)) n = int'(MAX_LINE_BYTES_DEF);
    return n / 3 * 3;
  endfunction

  task automatic encode_line();
    int                n;
    logic [BYTE_W-1:0] a, b, c, pad;
    logic [BYTE_W-1:0] g [4];
    n        = line_cnt;
    line_cnt = 0;
    pad      = uu_mode ? CH_UU_PAD : CH_B64_PAD;
    if (uu_mode) pending_chars.push_back('{ch: BYTE_W'(n) + UU_OFS, nl: 1'b0});
    for (int i = 0; i < n; i += 3) begin
      a = line_buf[i];
      b = (i + 1 < n) ? line_buf[i + 1] : '0;
      c = (i + 2 < n) ? line_buf[i + 2] : '0;
      g[0] = sextet_char(a[7:2], uu_mode);
      g[1] = sextet_char({a[1:0], b[7:4]}, uu_mode);
      g[2] = sextet_char({b[3:0], c[7:6]}, uu_mode);
      g[3] = sextet_char(c[5:0], uu_mode);
      if (i + 1 >= n) begin
        g[2] = pad;
        g[3] = pad;
      end else if (i + 2 >= n) begin
        g[3] = pad;
      end
      for (int j = 0; j < 4; j++) pending_chars.push_back('{ch: g[j], nl: 1'b0});
    end
    pending_chars.push_back('{ch: CH_NL, nl: 1'b1});
  endtask

  task automatic collect_byte(input logic [BYTE_W-1:0] d, input logic last);
    if (line_cnt < int'(MAX_LINE_BYTES_DEF)) begin
      line_buf[line_cnt] = d;
      line_cnt++;
    end
    if (line_cnt >= line_limit() || last) encode_line();
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    collect_byte(d, last);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] addr, input logic [CNT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_MODE) uu_mode = data[0];
    else line_cfg = data;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_tdata !== head_char.ch) begin
          $display("%0t: out_char mismatch, expected %h, actual %h",
                   $time, head_char.ch, out_tdata);
          errors++;
        end
        if (out_tlast !== head_char.nl) begin
          $display("%0t: last_of_run mismatch, expected %b, actual %b",
                   $time, head_char.nl, out_tlast);
          errors++;
        end
      end
    end
  end

  // one, two and three byte groups; 0xFB FF BF hits '+' and '/'
  task automatic test_base64_padding();
    write_reg(REG_MODE, 6'h3E);
    write_reg(REG_LINE, 6'd45);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    wait_drained();
  endtask

  task automatic test_uu_mode();
    write_reg(REG_MODE, 6'h3F);
    write_reg(REG_LINE, 6'd3);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_line_length_rounding();
    write_reg(REG_LINE, 6'd4);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    wait_drained();
    write_reg(REG_MODE, 6'h00);
    write_reg(REG_LINE, 6'd2);
    for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(255)), i == 3);
    wait_drained();
  endtask

  // shrink the line length with bytes already held: flushes on the next byte
  task automatic test_mid_line_shrink();
    for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    write_reg(REG_LINE, 6'd3);
    send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
  endtask

  function automatic logic [CNT_W-1:0] pick_line_len();
    case ($urandom_range(6))
      0:       return 6'd0;
      1:       return 6'd2;
      2:       return 6'd3;
      3:       return 6'd45;
      4:       return 6'd63;
      default: return CNT_W'($urandom_range(63));
    endcase
  endfunction

  task automatic test_random_traffic(input int target, input int s_idle, input int r_idle);
    int   first;
    int   len;
    logic end_mark;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    first         = bytes_sent;
    while (bytes_sent - first < target) begin
      if ($urandom_range(99) < 35) begin
        wait_drained();
        if ($urandom_range(1) == 1) write_reg(REG_MODE, CNT_W'($urandom_range(63)));
        write_reg(REG_LINE, pick_line_len());
      end
      len      = ($urandom_range(9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 12);
      end_mark = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)),
                  (i == len - 1 && end_mark) || ($urandom_range(49) == 0));
      end
    end
    wait_drained();
  endtask

  initial begin
    errors        = 0;
    bytes_sent    = 0;
    line_cnt      = 0;
    uu_mode       = 1'b0;
    line_cfg      = CNT_W'(MAX_LINE_BYTES_DEF);
    send_idle_pct = 26;
    recv_idle_pct = 62;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_base64_padding();
    test_uu_mode();
    test_line_length_rounding();
    test_mid_line_shrink();
    test_random_traffic(145, 26, 62);
    test_random_traffic(145, 62, 26);
    test_random_traffic(145, 0, 0);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_uu_base64_line_encoder_core: done, clean");
    end else begin
      $display("tb_uu_base64_line_encoder_core: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/uu64le_pkg.sv
sv/uu64le_store.sv
sv/uu64le_seq.sv
sv/uu_base64_line_encoder_core.sv
tb/tb_uu_base64_line_encoder_core.sv
